@@ design/bdca_pkg.sv @@
// ----------------------------------------------------------------------------
// bdca_pkg
// Types and constants shared by the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bdca_pkg;

	localparam int DIGIT_W        = 4;
	localparam int ASCII_W        = 6;
	localparam int STAGE_BITS     = 8;
	localparam int LOG2_SCALE     = 30103;
	localparam int LOG2_DIVISOR   = 100000;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [ASCII_W-1:0] ascii_t;

	localparam digit_t BCD_ADJ_LIMIT = digit_t'(5);
	localparam digit_t BCD_ADJ       = digit_t'(3);
	localparam ascii_t ASCII_ZERO    = ascii_t'(48);

	// Decimal digits needed for the largest value of a given bit width.
	function automatic int digit_count(input int width);
		return (width * LOG2_SCALE) / LOG2_DIVISOR + 1;
	endfunction

endpackage

@@ design/bdca_in_if.sv @@
// ----------------------------------------------------------------------------
// bdca_in_if
// Input channel: one binary value per transfer.
// ----------------------------------------------------------------------------
interface bdca_in_if #(
	parameter int VALUE_WIDTH = 32
) ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

@@ design/bdca_out_if.sv @@
// ----------------------------------------------------------------------------
// bdca_out_if
// Output channel: one ASCII digit per transfer, with an end-of-run flag.
// ----------------------------------------------------------------------------
interface bdca_out_if ();
	logic             valid;
	logic             ready;
	bdca_pkg::ascii_t ascii_digit;
	logic             last;

	modport source (output valid, output ascii_digit, output last, input ready);
	modport sink   (input valid, input ascii_digit, input last, output ready);
endinterface

@@ design/bdca_dabble_stage.sv @@
// ----------------------------------------------------------------------------
// bdca_dabble_stage
// One pipeline stage of the shift-and-add-3 conversion, eight bits deep.
// ----------------------------------------------------------------------------
module bdca_dabble_stage #(
	parameter int BIN_W = 32,
	parameter int NDIG  = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [NDIG*bdca_pkg::DIGIT_W-1:0] in_bcd,
	input  logic [BIN_W-1:0]                  in_bin,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [NDIG*bdca_pkg::DIGIT_W-1:0] out_bcd,
	output logic [BIN_W-1:0]                  out_bin
);
	import bdca_pkg::*;

	localparam int BCD_W = NDIG * DIGIT_W;

	logic             valid_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [BIN_W-1:0] bin_s1;
	logic [BCD_W-1:0] bcd_next;
	logic [BIN_W-1:0] bin_next;

	always_comb begin
		bcd_next = in_bcd;
		bin_next = in_bin;
		for (int step = 0; step < STAGE_BITS; step++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_next[d*DIGIT_W +: DIGIT_W] >= BCD_ADJ_LIMIT) begin
					bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + BCD_ADJ;
				end
			end
			{bcd_next, bin_next} = {bcd_next, bin_next} << 1;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_s1 <= bcd_next;
			bin_s1 <= bin_next;
		end
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bin   = bin_s1;

endmodule

@@ design/bdca_serializer.sv @@
// ----------------------------------------------------------------------------
// bdca_serializer
// Sends the BCD digits of one value as ASCII, most significant nonzero first.
// ----------------------------------------------------------------------------
module bdca_serializer #(
	parameter int NDIG = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [NDIG*bdca_pkg::DIGIT_W-1:0] in_bcd,
	bdca_out_if.source                        out_ch
);
	import bdca_pkg::*;

	localparam int BCD_W = NDIG * DIGIT_W;
	localparam int IDX_W = $clog2(NDIG);

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [BCD_W-1:0] bcd_q;
	logic [IDX_W-1:0] lead;
	logic             at_end;
	logic             load;
	digit_t           cur_digit;

	// Highest nonzero digit; a zero value leaves the index at the units digit.
	always_comb begin
		lead = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (in_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
				lead = IDX_W'(d);
			end
		end
	end

	assign at_end    = (idx_q == '0);
	assign in_ready  = !busy_q || (out_ch.ready && at_end);
	assign load      = in_valid && in_ready;
	assign cur_digit = bcd_q[idx_q*DIGIT_W +: DIGIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= lead;
		end else if (busy_q && out_ch.ready) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_bcd;
		end
	end

	assign out_ch.valid       = busy_q;
	assign out_ch.ascii_digit = ASCII_ZERO + ascii_t'(cur_digit);
	assign out_ch.last        = at_end;

`ifndef SYNTHESIS
	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q)
		else $error("run did not start after a load");

	a_stall_holds_index: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_ch.ready |=> busy_q && $stable(idx_q))
		else $error("digit index moved during a stall");

	a_index_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_ch.ready && !at_end |=> busy_q && (idx_q == $past(idx_q) - 1'b1))
		else $error("digit index did not step down after a transfer");

	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> at_end || (cur_digit != '0))
		else $error("run starts with a leading zero");
`endif

endmodule

@@ design/binary_to_decimal_ascii.sv @@
// A value passes through ceil(VALUE_WIDTH/8) conversion stages and then the output register
// of the serializer before its first character is sent.
// Throughput: one character per cycle while out_ch.ready is high; each value gives
// max(1, digits) characters, at most 10 at the default width, on the single character port.
// Conversion stages accept a new value every cycle and hold under back-pressure.
// Reset clears all valid bits and the output run; no values are kept across reset.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary value into a run of ASCII decimal digits.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bdca_in_if.sink    in_ch,
	bdca_out_if.source out_ch
);
	import bdca_pkg::*;

	localparam int NDIG    = digit_count(VALUE_WIDTH);
	localparam int BCD_W   = NDIG * DIGIT_W;
	localparam int NSTAGES = (VALUE_WIDTH + STAGE_BITS - 1) / STAGE_BITS;
	localparam int PAD_W   = NSTAGES * STAGE_BITS;

	logic [NSTAGES:0]            chain_valid;
	logic [NSTAGES:0]            chain_ready;
	logic [NSTAGES:0][BCD_W-1:0] chain_bcd;
	logic [NSTAGES:0][PAD_W-1:0] chain_bin;

	assign chain_valid[0] = in_ch.valid;
	assign in_ch.ready    = chain_ready[0];
	assign chain_bcd[0]   = '0;
	assign chain_bin[0]   = PAD_W'(in_ch.value);

	for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
		bdca_dabble_stage #(
			.BIN_W (PAD_W),
			.NDIG  (NDIG)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[s]),
			.in_ready  (chain_ready[s]),
			.in_bcd    (chain_bcd[s]),
			.in_bin    (chain_bin[s]),
			.out_valid (chain_valid[s+1]),
			.out_ready (chain_ready[s+1]),
			.out_bcd   (chain_bcd[s+1]),
			.out_bin   (chain_bin[s+1])
		);
	end

	bdca_serializer #(
		.NDIG (NDIG)
	) u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[NSTAGES]),
		.in_ready (chain_ready[NSTAGES]),
		.in_bcd   (chain_bcd[NSTAGES]),
		.out_ch   (out_ch)
	);

endmodule
